>>> design/rpc_pkg.sv
// ----------------------------------------------------------------------------
// Relativistic primitive-to-conserved package
// Shared beat types, status codes and configuration constants of the
// special-relativistic ideal-gas converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  // Input beat: one cell's primitive state.
  typedef struct packed {
    logic        [31:0] rest_density;
    logic        [31:0] gas_pressure;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
  } rpc_in_t;

  // Result beat: one cell's conserved state.
  typedef struct packed {
    logic signed [47:0] conserved_density;
    logic signed [47:0] momentum_x;
    logic signed [47:0] momentum_y;
    logic signed [47:0] momentum_z;
    logic signed [47:0] total_energy;
    logic        [1:0]  status;
  } rpc_out_t;

  // Side band that travels down the pipeline with each beat.
  typedef struct packed {
    logic [1:0]       spec;
    logic [31:0]      rho;
    logic [31:0]      pres;
    logic [51:0]      enth;
    logic [2:0][31:0] vmag;
    logic [2:0]       vneg;
  } rpc_meta_t;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_SUPERLUMINAL = 2'd1;
  localparam logic [1:0] STATUS_NO_DENSITY  = 2'd2;
  localparam logic [1:0] STATUS_SATURATED   = 2'd3;

  localparam logic [17:0] GAMMA_RESET = 18'd109227;
  localparam logic [17:0] ONE_Q16     = 18'd65536;
  localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam logic [5:0]  KDIV_STEPS  = 6'd50;

endpackage

`default_nettype wire

>>> design/relativistic_prim_to_cons_unit.sv
// ----------------------------------------------------------------------------
// Relativistic primitive-to-conserved converter
// Turns rest density, pressure and velocity of one cell into conserved
// density, momenta and total energy for an ideal gas.
// ----------------------------------------------------------------------------
//  channel   signals                                 direction
//  command   start, busy, in_i                       in (busy out)
//  result    done_o, result_o                        out
//  config    cfg_valid_i, cfg_ready_o, cfg_data_i    in (cfg_ready_o out)
//
//  One cell is taken every clock while busy is low; its result appears on
//  done_o once it has passed every pipeline stage. The depth comes from the
//  square root (32 stages, one root bit each) and the Lorentz factor divider
//  (63 stages, one quotient bit each). After reset and after each config
//  write a serial divider forms g/(g-1); busy and !cfg_ready_o are high
//  meanwhile. The pipeline never stalls because results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module relativistic_prim_to_cons_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rpc_pkg::rpc_in_t  in_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [17:0]       cfg_data_i,
  output logic              done_o,
  output rpc_pkg::rpc_out_t result_o
);

  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 63;
  localparam int LATENCY  = 106;

  // --------------------------------------------------------------------------
  // g/(g-1) in Q.32, formed by a serial restoring divider.
  // --------------------------------------------------------------------------
  logic [17:0] gamma_q;
  logic [49:0] kacc_q;
  logic [17:0] krem_q;
  logic [5:0]  kcnt_q;
  logic        kbusy_q;
  logic [18:0] krem_sh;
  logic [18:0] kdiv;
  logic        kge;
  logic [18:0] krem_sub;
  logic        gamma_le_one;

  assign krem_sh      = {krem_q, kacc_q[49]};
  assign kdiv         = {1'b0, gamma_q - rpc_pkg::ONE_Q16};
  assign kge          = krem_sh >= kdiv;
  assign krem_sub     = krem_sh - kdiv;
  assign gamma_le_one = gamma_q <= rpc_pkg::ONE_Q16;
  assign busy         = kbusy_q;
  assign cfg_ready_o  = !kbusy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= rpc_pkg::GAMMA_RESET;
      kacc_q  <= {rpc_pkg::GAMMA_RESET, 32'd0};
      krem_q  <= '0;
      kcnt_q  <= rpc_pkg::KDIV_STEPS;
      kbusy_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gamma_q <= cfg_data_i;
      kacc_q  <= {cfg_data_i, 32'd0};
      krem_q  <= '0;
      kcnt_q  <= rpc_pkg::KDIV_STEPS;
      kbusy_q <= 1'b1;
    end else if (kbusy_q) begin
      kacc_q <= {kacc_q[48:0], kge};
      krem_q <= kge ? krem_sub[17:0] : krem_sh[17:0];
      kcnt_q <= kcnt_q - 6'd1;
      if (kcnt_q == 6'd1) begin
        kbusy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: input capture.
  // --------------------------------------------------------------------------
  logic             a_v_q;
  rpc_pkg::rpc_in_t a_in_q;
  logic [2:0][31:0] a_raw;
  logic [2:0][31:0] a_mag;
  logic [2:0]       a_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a_in_q <= in_i;
  end

  assign a_raw[0] = a_in_q.velocity_x;
  assign a_raw[1] = a_in_q.velocity_y;
  assign a_raw[2] = a_in_q.velocity_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_neg[i] = a_raw[i][31];
      a_mag[i] = a_neg[i] ? (32'd0 - a_raw[i]) : a_raw[i];
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: velocity squares and k*p partial products.
  // --------------------------------------------------------------------------
  logic             b_v_q;
  logic [2:0][63:0] b_sq_q;
  logic [63:0]      b_kp0_q;
  logic [49:0]      b_kp1_q;
  logic [31:0]      b_rho_q;
  logic [31:0]      b_pres_q;
  logic [2:0][31:0] b_vmag_q;
  logic [2:0]       b_vneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      b_sq_q[i] <= a_mag[i] * a_mag[i];
    end
    b_kp0_q  <= kacc_q[31:0] * a_in_q.gas_pressure;
    b_kp1_q  <= kacc_q[49:32] * a_in_q.gas_pressure;
    b_rho_q  <= a_in_q.rest_density;
    b_pres_q <= a_in_q.gas_pressure;
    b_vmag_q <= a_mag;
    b_vneg_q <= a_neg;
  end

  // --------------------------------------------------------------------------
  // Stage C (square root entry): v^2, special cases, enthalpy density.
  // --------------------------------------------------------------------------
  logic [63:0]        c_v2;
  logic [63:0]        c_gap;
  rpc_pkg::rpc_meta_t c_meta;

  logic [63:0]        sr_rem_q  [0:SQ_STEPS];
  logic [31:0]        sr_root_q [0:SQ_STEPS];
  rpc_pkg::rpc_meta_t sr_meta_q [0:SQ_STEPS];
  logic               sr_v_q    [0:SQ_STEPS];

  assign c_v2  = b_sq_q[0] + b_sq_q[1] + b_sq_q[2];
  assign c_gap = rpc_pkg::ONE_Q60 - c_v2;

  always_comb begin
    c_meta.rho  = b_rho_q;
    c_meta.pres = b_pres_q;
    c_meta.enth = {2'd0, b_kp1_q} + {20'd0, b_rho_q} + {20'd0, b_kp0_q[63:32]};
    c_meta.vmag = b_vmag_q;
    c_meta.vneg = b_vneg_q;
    if (c_v2 >= rpc_pkg::ONE_Q60) begin
      c_meta.spec = rpc_pkg::STATUS_SUPERLUMINAL;
    end else if (b_rho_q == 32'd0) begin
      c_meta.spec = rpc_pkg::STATUS_NO_DENSITY;
    end else if (gamma_le_one) begin
      c_meta.spec = rpc_pkg::STATUS_SATURATED;
    end else begin
      c_meta.spec = rpc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_v_q[0] <= 1'b0;
    end else begin
      sr_v_q[0] <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_rem_q[0]  <= {c_gap[61:0], 2'b00};
    sr_root_q[0] <= '0;
    sr_meta_q[0] <= c_meta;
  end

  // Square root: one root bit per stage, remainder kept as x - root^2.
  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    localparam int B = SQ_STEPS - k;
    logic [65:0] trial;
    logic        take;

    assign trial = ({34'd0, sr_root_q[k-1]} << (B + 1)) + (66'd1 << (2 * B));
    assign take  = {2'd0, sr_rem_q[k-1]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[k] <= 1'b0;
      end else begin
        sr_v_q[k] <= sr_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      sr_rem_q[k]  <= take ? (sr_rem_q[k-1] - trial[63:0]) : sr_rem_q[k-1];
      sr_root_q[k] <= take ? (sr_root_q[k-1] | (32'd1 << B)) : sr_root_q[k-1];
      sr_meta_q[k] <= sr_meta_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Lorentz factor W = 2^63 / s, one quotient bit per stage. The top
  // numerator bit is already folded in as a starting remainder of one.
  // --------------------------------------------------------------------------
  logic [31:0]        dv_rem_q  [0:DV_STEPS];
  logic [62:0]        dv_quo_q  [0:DV_STEPS];
  logic [31:0]        dv_s_q    [0:DV_STEPS];
  rpc_pkg::rpc_meta_t dv_meta_q [0:DV_STEPS];
  logic               dv_v_q    [0:DV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= sr_v_q[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_rem_q[0]  <= 32'd1;
    dv_quo_q[0]  <= '0;
    dv_s_q[0]    <= sr_root_q[SQ_STEPS];
    dv_meta_q[0] <= sr_meta_q[SQ_STEPS];
  end

  for (genvar k = 1; k <= DV_STEPS; k++) begin : g_div
    logic [32:0] rem2;
    logic [32:0] diff;
    logic        take;

    assign rem2 = {dv_rem_q[k-1], 1'b0};
    assign diff = rem2 - {1'b0, dv_s_q[k-1]};
    assign take = rem2 >= {1'b0, dv_s_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else begin
        dv_v_q[k] <= dv_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_rem_q[k]  <= take ? diff[31:0] : rem2[31:0];
      dv_quo_q[k]  <= {dv_quo_q[k-1][61:0], take};
      dv_s_q[k]    <= dv_s_q[k-1];
      dv_meta_q[k] <= dv_meta_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Product stages. Each wide product is split into 32-bit partials that are
  // registered before they are summed.
  // --------------------------------------------------------------------------
  logic [62:0] w_lor;
  assign w_lor = dv_quo_q[DV_STEPS];

  // M1: W*W and rho*W partials.
  logic               m1_v_q;
  logic [63:0]        m1_p00_q;
  logic [62:0]        m1_p01_q;
  logic [61:0]        m1_p11_q;
  logic [63:0]        m1_r0_q;
  logic [62:0]        m1_r1_q;
  rpc_pkg::rpc_meta_t m1_meta_q;

  always_ff @(posedge clk_i) begin
    m1_p00_q  <= w_lor[31:0] * w_lor[31:0];
    m1_p01_q  <= w_lor[31:0] * w_lor[62:32];
    m1_p11_q  <= w_lor[62:32] * w_lor[62:32];
    m1_r0_q   <= dv_meta_q[DV_STEPS].rho * w_lor[31:0];
    m1_r1_q   <= dv_meta_q[DV_STEPS].rho * w_lor[62:32];
    m1_meta_q <= dv_meta_q[DV_STEPS];
  end

  // M2: W^2 with saturation, conserved density.
  logic               m2_v_q;
  logic [125:0]       m2_ww;
  logic               m2_sat;
  logic [63:0]        m2_w2_q;
  logic               m2_sat_q;
  logic [63:0]        m2_dens_q;
  rpc_pkg::rpc_meta_t m2_meta_q;

  assign m2_ww  = {m1_p11_q, 64'd0} + {30'd0, m1_p01_q, 33'd0} + {62'd0, m1_p00_q};
  assign m2_sat = |m2_ww[125:96];

  always_ff @(posedge clk_i) begin
    m2_w2_q   <= m2_sat ? '1 : m2_ww[95:32];
    m2_sat_q  <= m2_sat;
    m2_dens_q <= {1'b0, m1_r1_q} + {32'd0, m1_r0_q[63:32]};
    m2_meta_q <= m1_meta_q;
  end

  // M3: enthalpy times W^2 partials.
  logic               m3_v_q;
  logic [63:0]        m3_q00_q;
  logic [63:0]        m3_q01_q;
  logic [51:0]        m3_q10_q;
  logic [51:0]        m3_q11_q;
  logic               m3_sat_q;
  logic [63:0]        m3_dens_q;
  rpc_pkg::rpc_meta_t m3_meta_q;

  always_ff @(posedge clk_i) begin
    m3_q00_q  <= m2_meta_q.enth[31:0] * m2_w2_q[31:0];
    m3_q01_q  <= m2_meta_q.enth[31:0] * m2_w2_q[63:32];
    m3_q10_q  <= m2_meta_q.enth[51:32] * m2_w2_q[31:0];
    m3_q11_q  <= m2_meta_q.enth[51:32] * m2_w2_q[63:32];
    m3_sat_q  <= m2_sat_q;
    m3_dens_q <= m2_dens_q;
    m3_meta_q <= m2_meta_q;
  end

  // M4: alpha = rho*h*W^2 with saturation.
  logic               m4_v_q;
  logic [117:0]       m4_sum;
  logic               m4_sat;
  logic [63:0]        m4_alpha_q;
  logic               m4_sat_q;
  logic [63:0]        m4_dens_q;
  rpc_pkg::rpc_meta_t m4_meta_q;

  assign m4_sum = {2'd0, m3_q11_q, 64'd0} + {22'd0, m3_q01_q, 32'd0}
                + {34'd0, m3_q10_q, 32'd0} + {54'd0, m3_q00_q};
  assign m4_sat = |m4_sum[117:96];

  always_ff @(posedge clk_i) begin
    m4_alpha_q <= m4_sat ? '1 : m4_sum[95:32];
    m4_sat_q   <= m3_sat_q || m4_sat;
    m4_dens_q  <= m3_dens_q;
    m4_meta_q  <= m3_meta_q;
  end

  // M5: momentum partials and energy magnitude.
  logic               m5_v_q;
  logic [2:0][63:0]   m5_lo_q;
  logic [2:0][63:0]   m5_hi_q;
  logic [63:0]        m5_emag_q;
  logic               m5_eneg_q;
  logic               m5_sat_q;
  logic [63:0]        m5_dens_q;
  rpc_pkg::rpc_meta_t m5_meta_q;
  logic [63:0]        m5_pres;
  logic               m5_eneg;

  assign m5_pres = {32'd0, m4_meta_q.pres};
  assign m5_eneg = m4_alpha_q < m5_pres;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m5_lo_q[i] <= m4_meta_q.vmag[i] * m4_alpha_q[31:0];
      m5_hi_q[i] <= m4_meta_q.vmag[i] * m4_alpha_q[63:32];
    end
    m5_emag_q <= m5_eneg ? (m5_pres - m4_alpha_q) : (m4_alpha_q - m5_pres);
    m5_eneg_q <= m5_eneg;
    m5_sat_q  <= m4_sat_q;
    m5_dens_q <= m4_dens_q;
    m5_meta_q <= m4_meta_q;
  end

  // M6: momentum magnitudes, scaled by 2^-30 with saturation.
  logic               m6_v_q;
  logic [2:0][95:0]   m6_prod;
  logic [2:0]         m6_ssat;
  logic [2:0][63:0]   m6_smag_q;
  logic [63:0]        m6_emag_q;
  logic               m6_eneg_q;
  logic               m6_sat_q;
  logic [63:0]        m6_dens_q;
  rpc_pkg::rpc_meta_t m6_meta_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m6_prod[i] = {m5_hi_q[i], 32'd0} + {32'd0, m5_lo_q[i]};
      m6_ssat[i] = |m6_prod[i][95:94];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m6_smag_q[i] <= m6_ssat[i] ? '1 : m6_prod[i][93:30];
    end
    m6_emag_q <= m5_emag_q;
    m6_eneg_q <= m5_eneg_q;
    m6_sat_q  <= m5_sat_q || (|m6_ssat);
    m6_dens_q <= m5_dens_q;
    m6_meta_q <= m5_meta_q;
  end

  // --------------------------------------------------------------------------
  // Output stage: 48-bit encoding with saturation, special cases.
  // --------------------------------------------------------------------------
  function automatic logic [48:0] enc48(input logic [63:0] mag, input logic neg);
    logic [63:0] neg_val;
    neg_val = ~mag + 64'd1;
    if (neg) begin
      if (mag > 64'h0000_8000_0000_0000) begin
        return {1'b1, 48'h8000_0000_0000};
      end
      return {1'b0, neg_val[47:0]};
    end
    if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
      return {1'b1, 48'h7FFF_FFFF_FFFF};
    end
    return {1'b0, mag[47:0]};
  endfunction

  logic              out_v_q;
  rpc_pkg::rpc_out_t res_q;
  logic [48:0]       e_dens;
  logic [2:0][48:0]  e_mom;
  logic [48:0]       e_energy;
  rpc_pkg::rpc_out_t res_d;

  always_comb begin
    e_dens   = enc48(m6_dens_q, 1'b0);
    for (int i = 0; i < 3; i++) begin
      e_mom[i] = enc48(m6_smag_q[i], m6_meta_q.vneg[i]);
    end
    e_energy = enc48(m6_emag_q, m6_eneg_q);
    if (m6_meta_q.spec != rpc_pkg::STATUS_OK) begin
      res_d        = '0;
      res_d.status = m6_meta_q.spec;
    end else begin
      res_d.conserved_density = e_dens[47:0];
      res_d.momentum_x        = e_mom[0][47:0];
      res_d.momentum_y        = e_mom[1][47:0];
      res_d.momentum_z        = e_mom[2][47:0];
      res_d.total_energy      = e_energy[47:0];
      if (m6_sat_q || e_dens[48] || e_mom[0][48] || e_mom[1][48] || e_mom[2][48]
          || e_energy[48]) begin
        res_d.status = rpc_pkg::STATUS_SATURATED;
      end else begin
        res_d.status = rpc_pkg::STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      m3_v_q  <= 1'b0;
      m4_v_q  <= 1'b0;
      m5_v_q  <= 1'b0;
      m6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      m1_v_q  <= dv_v_q[DV_STEPS];
      m2_v_q  <= m1_v_q;
      m3_v_q  <= m2_v_q;
      m4_v_q  <= m3_v_q;
      m5_v_q  <= m4_v_q;
      m6_v_q  <= m5_v_q;
      out_v_q <= m6_v_q;
    end
  end

  assign done_o   = out_v_q;
  assign result_o = res_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY done_o)
    else $error("accepted beat did not produce a result after the pipeline depth");

  a_cfg_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> busy)
    else $error("config write did not restart the g/(g-1) divider");

  a_special_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status == rpc_pkg::STATUS_SUPERLUMINAL
               || result_o.status == rpc_pkg::STATUS_NO_DENSITY)
    |-> result_o.conserved_density == '0 && result_o.momentum_x == '0
        && result_o.momentum_y == '0 && result_o.momentum_z == '0
        && result_o.total_energy == '0)
    else $error("special-case result carries nonzero values");

endmodule

`default_nettype wire

>>> test/relativistic_prim_to_cons_checker.sv
// ----------------------------------------------------------------------------
// Relativistic primitive-to-conserved checker
// Watches the command, result and configuration channels of the converter.
// It predicts the conserved state of every accepted cell and compares each
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module relativistic_prim_to_cons_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  rpc_pkg::rpc_in_t  in_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic [17:0]       cfg_data_i,
  input  logic              done_o,
  input  rpc_pkg::rpc_out_t result_o,
  output int                errors_o,
  output int                pending_o,
  output int                cells_o,
  output int                saturated_o,
  output int                special_o
);

  rpc_pkg::rpc_out_t conserved_q[$];
  logic [17:0]       gamma_q;

  // (a*b) >> sh, held at all ones when it does not fit in 64 bits.
  function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                 input int sh, inout bit sat);
    logic [127:0] full;
    full = ({64'd0, a} * {64'd0, b}) >> sh;
    if (full[127:64] != 0) begin
      sat = 1'b1;
      return '1;
    end
    return full[63:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [65:0] r;
    logic [65:0] t;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (66'd1 << b);
      if (t * t <= {2'b00, x}) r = t;
    end
    return r[63:0];
  endfunction

  // Signed magnitude to Q32.16, clamped to the 48-bit range.
  function automatic logic [47:0] to_q32_16(input logic [63:0] mag, input bit neg,
                                            inout bit sat);
    logic [63:0] m;
    m = mag;
    if (neg) begin
      if (m > 64'h8000_0000_0000) begin
        m = 64'h8000_0000_0000;
        sat = 1'b1;
      end
      return 48'(~m + 64'd1);
    end
    if (m > 64'h7FFF_FFFF_FFFF) begin
      m = 64'h7FFF_FFFF_FFFF;
      sat = 1'b1;
    end
    return m[47:0];
  endfunction

  function automatic rpc_pkg::rpc_out_t conserved_state(input rpc_pkg::rpc_in_t c,
                                                        input logic [17:0] g);
    rpc_pkg::rpc_out_t r;
    logic [31:0] raw[3];
    logic [63:0] mag[3];
    bit          neg[3];
    logic [63:0] v2, lorentz, lorentz2, kappa, enth, alpha, g64;
    bit          sat;
    raw[0] = c.velocity_x;
    raw[1] = c.velocity_y;
    raw[2] = c.velocity_z;
    v2 = '0;
    sat = 1'b0;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = raw[i][31];
      mag[i] = neg[i] ? (64'h1_0000_0000 - {32'd0, raw[i]}) : {32'd0, raw[i]};
      v2 += mag[i] * mag[i];
    end
    if (v2 >= rpc_pkg::ONE_Q60) begin
      r.status = rpc_pkg::STATUS_SUPERLUMINAL;
      return r;
    end
    if (c.rest_density == 0) begin
      r.status = rpc_pkg::STATUS_NO_DENSITY;
      return r;
    end
    if (g <= rpc_pkg::ONE_Q16) begin
      r.status = rpc_pkg::STATUS_SATURATED;
      return r;
    end
    g64 = {46'd0, g};
    lorentz = (64'd1 << 63) / root_floor((rpc_pkg::ONE_Q60 - v2) << 2);
    lorentz2 = scaled_product(lorentz, lorentz, 32, sat);
    kappa = (g64 << 32) / (g64 - 64'd65536);
    enth = {32'd0, c.rest_density} + scaled_product(kappa, {32'd0, c.gas_pressure}, 32, sat);
    r.conserved_density = to_q32_16(scaled_product({32'd0, c.rest_density}, lorentz, 32, sat),
                                    1'b0, sat);
    alpha = scaled_product(enth, lorentz2, 32, sat);
    r.momentum_x = to_q32_16(scaled_product(mag[0], alpha, 30, sat), neg[0], sat);
    r.momentum_y = to_q32_16(scaled_product(mag[1], alpha, 30, sat), neg[1], sat);
    r.momentum_z = to_q32_16(scaled_product(mag[2], alpha, 30, sat), neg[2], sat);
    if (alpha >= {32'd0, c.gas_pressure})
      r.total_energy = to_q32_16(alpha - {32'd0, c.gas_pressure}, 1'b0, sat);
    else
      r.total_energy = to_q32_16({32'd0, c.gas_pressure} - alpha, 1'b1, sat);
    r.status = sat ? rpc_pkg::STATUS_SATURATED : rpc_pkg::STATUS_OK;
    return r;
  endfunction

  assign pending_o = conserved_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    rpc_pkg::rpc_out_t want;
    if (!rst_ni) begin
      gamma_q <= rpc_pkg::GAMMA_RESET;
      errors_o <= 0;
      cells_o <= 0;
      saturated_o <= 0;
      special_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) gamma_q <= cfg_data_i;
      if (start && !busy) begin
        conserved_q.push_back(conserved_state(in_i, gamma_q));
        cells_o <= cells_o + 1;
      end
      if (done_o) begin
        if (conserved_q.size() == 0) begin
          $error("result beat with no cell outstanding");
          errors_o <= errors_o + 1;
        end else begin
          want = conserved_q.pop_front();
          if (want.status == rpc_pkg::STATUS_SATURATED) saturated_o <= saturated_o + 1;
          if (want.status == rpc_pkg::STATUS_SUPERLUMINAL
              || want.status == rpc_pkg::STATUS_NO_DENSITY)
            special_o <= special_o + 1;
          if (result_o != want) errors_o <= errors_o + 1;
          if (result_o.conserved_density != want.conserved_density)
            $error("conserved_density: expected %0d, got %0d",
                   want.conserved_density, result_o.conserved_density);
          if (result_o.momentum_x != want.momentum_x)
            $error("momentum_x: expected %0d, got %0d", want.momentum_x, result_o.momentum_x);
          if (result_o.momentum_y != want.momentum_y)
            $error("momentum_y: expected %0d, got %0d", want.momentum_y, result_o.momentum_y);
          if (result_o.momentum_z != want.momentum_z)
            $error("momentum_z: expected %0d, got %0d", want.momentum_z, result_o.momentum_z);
          if (result_o.total_energy != want.total_energy)
            $error("total_energy: expected %0d, got %0d",
                   want.total_energy, result_o.total_energy);
          if (result_o.status != want.status)
            $error("status: expected %0d, got %0d", want.status, result_o.status);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> test/relativistic_prim_to_cons_unit_tb.sv
// ----------------------------------------------------------------------------
// Relativistic primitive-to-conserved testbench
// Drives directed and random cells through the converter under several
// adiabatic indexes and sender idle rates; a checker scores every result.
// ----------------------------------------------------------------------------
`default_nettype none

module relativistic_prim_to_cons_unit_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 120;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  rpc_pkg::rpc_in_t  in_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [17:0]       cfg_data_i = '0;
  logic              done_o;
  rpc_pkg::rpc_out_t result_o;
  int                errors, pending, cells, saturated, special;
  int                idle_pct = 0;
  int                quiet_cycles = 0;
  int                gamma_writes = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  relativistic_prim_to_cons_unit DUT (
    .clk_i, .rst_ni, .start, .busy, .in_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .done_o, .result_o
  );

  relativistic_prim_to_cons_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .in_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .done_o, .result_o,
    .errors_o(errors), .pending_o(pending), .cells_o(cells),
    .saturated_o(saturated), .special_o(special)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Busy only moves at rising edges, so its value at the falling edge is the
  // one the next rising edge sees.
  task automatic send_cell(input rpc_pkg::rpc_in_t c);
    bit taken;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    in_i <= c;
    do begin
      taken = !busy;
      @(negedge clk_i);
    end while (!taken);
  endtask

  task automatic write_gamma(input logic [17:0] g);
    bit taken;
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= g;
    do begin
      taken = cfg_ready_o;
      @(negedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    gamma_writes++;
  endtask

  function automatic rpc_pkg::rpc_in_t make_cell(input logic [31:0] rho,
                                                 input logic [31:0] p,
                                                 input logic [31:0] vx, input logic [31:0] vy,
                                                 input logic [31:0] vz);
    rpc_pkg::rpc_in_t c;
    c.rest_density = rho;
    c.gas_pressure = p;
    c.velocity_x = vx;
    c.velocity_y = vy;
    c.velocity_z = vz;
    return c;
  endfunction

  function automatic logic [31:0] random_speed_component(input int shift);
    logic signed [31:0] v;
    v = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    return v >>> shift;
  endfunction

  function automatic rpc_pkg::rpc_in_t random_cell();
    rpc_pkg::rpc_in_t c;
    int          pick;
    int          sh;
    logic [31:0] vx;
    pick = $urandom_range(0, 99);
    sh = $urandom_range(1, 6);
    c.rest_density = $urandom >> $urandom_range(0, 24);
    c.gas_pressure = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 49) == 0) c.rest_density = '0;
    if (pick < 10) begin
      // Raw bit patterns, mostly beyond light speed.
      c.velocity_x = $urandom;
      c.velocity_y = $urandom;
      c.velocity_z = $urandom;
    end else if (pick < 25) begin
      // One component close to light speed.
      vx = 32'h4000_0000 - ($urandom >> $urandom_range(4, 31));
      c.velocity_x = $urandom_range(0, 1) ? vx : -vx;
      c.velocity_y = random_speed_component(20);
      c.velocity_z = random_speed_component(24);
    end else begin
      c.velocity_x = random_speed_component(sh);
      c.velocity_y = random_speed_component($urandom_range(1, 8));
      c.velocity_z = random_speed_component($urandom_range(1, 8));
    end
    return c;
  endfunction

  task automatic run_directed();
    send_cell(make_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0));
    send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
    send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3FFF_FFFF, 32'h0, 32'h0));
    send_cell(make_cell(32'h0000_0001, 32'h0000_0001, 32'hC000_0001, 32'h0, 32'h0));
    send_cell(make_cell(32'h0, 32'h0001_0000, 32'h1000_0000, 32'h0, 32'h0));
    send_cell(make_cell(32'h0, 32'h0, 32'h4000_0000, 32'h0, 32'h0));
    send_cell(make_cell(32'h0001_0000, 32'h0, 32'h4000_0000, 32'h0, 32'h0));
    send_cell(make_cell(32'h0001_0000, 32'h0, 32'h0, 32'hC000_0000, 32'h0));
    send_cell(make_cell(32'h0001_0000, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_cell(make_cell(32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0));
    send_cell(make_cell(32'h0001_0000, 32'h0, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000));
    send_cell(make_cell(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 32'h3FFF_FFFF));
    send_cell(make_cell(32'h0000_0001, 32'hFFFF_FFFF, 32'hE000_0000, 32'h1000_0000,
                        32'hF000_0000));
    send_cell(make_cell(32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0));
    send_cell(make_cell(32'h0000_8000, 32'h8000_0000, 32'h3FFF_0000, 32'h0000_1000,
                        32'hFFFF_0000));
  endtask

  initial begin
    logic [17:0] gammas[6];
    gammas[0] = rpc_pkg::GAMMA_RESET;
    gammas[1] = 18'd65537;
    gammas[2] = 18'd196608;
    gammas[3] = rpc_pkg::ONE_Q16;
    gammas[4] = 18'($urandom_range(65537, 196608));
    gammas[5] = 18'd98304;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int ph = 0; ph < 6; ph++) begin
      write_gamma(gammas[ph]);
      if (ph == 0 || ph == 1 || ph == 3) run_directed();
      for (int n = 0; n < 250; n++) begin
        idle_pct = (cells < 500) ? 7 : (cells < 1000) ? 87 : 0;
        send_cell(random_cell());
      end
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Converted %0d cells under %0d adiabatic index settings.", cells, gamma_writes);
    $display("%0d cells hit light speed or zero density, %0d saturated.", special, saturated);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/rpc_pkg.sv
design/relativistic_prim_to_cons_unit.sv
test/relativistic_prim_to_cons_checker.sv
test/relativistic_prim_to_cons_unit_tb.sv
